/* src/pda_pkg.sv */
// shared types, register codes and saturating arithmetic for the pid core
`default_nettype none
package pda_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 5;

  typedef enum logic [2:0] {
    REG_GAIN_PROP       = 3'd0,
    REG_GAIN_INTEG      = 3'd1,
    REG_DERIV_POLE      = 3'd2,
    REG_GAIN_DERIV      = 3'd3,
    REG_GAIN_ANTIWINDUP = 3'd4,
    REG_DEAD_BAND       = 3'd5,
    REG_OUT_LIMIT       = 3'd6,
    REG_MODE_BITS       = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEG,
    ST_ERR,
    ST_DBAND,
    ST_PREP,
    ST_MUL_I,
    ST_MUL_DP,
    ST_MUL_DG,
    ST_SUM_D,
    ST_TOTAL,
    ST_CLIP,
    ST_CERR,
    ST_MUL_AW,
    ST_FIN
  } state_t;

  localparam logic signed [31:0] S32Max = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32Min = 32'sh8000_0000;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7fff_ffff) r = S32Max;
    else if (v < -34'sh0_8000_0000) r = S32Min;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [33:0] s;
    s = 34'(a) + 34'(b);
    return sat34(s);
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [33:0] s;
    s = 34'(a) - 34'(b);
    return sat34(s);
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] a);
    logic signed [31:0] r;
    if (a == S32Min) r = S32Max;
    else r = -a;
    return r;
  endfunction

  // q8.24 times q16.16 product back to q16.16, round half up, saturate
  function automatic logic signed [31:0] round_sat(input logic signed [63:0] p);
    logic signed [63:0] pr;
    logic signed [39:0] q;
    logic signed [31:0] r;
    pr = p + 64'sd8388608;
    q = pr[63:24];
    if (q > 40'sh00_7fff_ffff) r = S32Max;
    else if (q < -40'sh00_8000_0000) r = S32Min;
    else r = q[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/pid_deadband_antiwindup_core.sv */
// pid controller with dead band, filtered derivative and anti-windup
// one request at a time, sequenced through the shared 32x32 multiplier;
// the input stalls while a request is in flight
// a finished result waits in the output register without blocking the next request
// reset: synchronous, clears config registers to zero but out_limit to max, fsm and history/accumulators to zero
`default_nettype none
module pid_deadband_antiwindup_core
  import pda_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [AddrW-1:0]        paddr,
  input  wire logic [DataW-1:0]        pwdata,
  output logic      [DataW-1:0]        prdata,
  output logic                         pready,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [31:0]      command_value,
  input  wire logic signed [31:0]      measured_value,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [31:0]           drive_value
);

  logic signed [31:0] gain_prop;
  logic signed [31:0] gain_integ;
  logic signed [31:0] deriv_pole;
  logic signed [31:0] gain_deriv;
  logic signed [31:0] gain_antiwindup;
  logic        [30:0] dead_band;
  logic        [30:0] out_limit;
  logic        [2:0]  mode_bits;

  logic signed [31:0] last_error;
  logic signed [31:0] last_neg_measure;
  logic signed [31:0] integ_accum;
  logic signed [31:0] deriv_accum;

  state_t state, state_next;

  logic signed [31:0] cmd, act, neg_act, e, esum, diff;
  logic signed [31:0] yp, yi, ydp, yd, y, ys, clip_err;
  logic               gd_zero;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [31:0] mq;
  logic        [31:0] mag;
  logic               cfg_wr;
  logic               out_free;
  reg_idx_t           cfg_idx;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign cfg_idx  = reg_idx_t'(paddr[4:2]);
  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign mq       = round_sat(prod);
  assign mag      = e[31] ? 32'(-33'(e)) : e;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop       <= '0;
      gain_integ      <= '0;
      deriv_pole      <= '0;
      gain_deriv      <= '0;
      gain_antiwindup <= '0;
      dead_band       <= '0;
      out_limit       <= '1;
      mode_bits       <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GAIN_PROP:       gain_prop       <= pwdata;
        REG_GAIN_INTEG:      gain_integ      <= pwdata;
        REG_DERIV_POLE:      deriv_pole      <= pwdata;
        REG_GAIN_DERIV:      gain_deriv      <= pwdata;
        REG_GAIN_ANTIWINDUP: gain_antiwindup <= pwdata;
        REG_DEAD_BAND:       dead_band       <= pwdata[30:0];
        REG_OUT_LIMIT:       out_limit       <= pwdata[30:0];
        REG_MODE_BITS:       mode_bits       <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GAIN_PROP:       prdata = gain_prop;
      REG_GAIN_INTEG:      prdata = gain_integ;
      REG_DERIV_POLE:      prdata = deriv_pole;
      REG_GAIN_DERIV:      prdata = gain_deriv;
      REG_GAIN_ANTIWINDUP: prdata = gain_antiwindup;
      REG_DEAD_BAND:       prdata = {1'b0, dead_band};
      REG_OUT_LIMIT:       prdata = {1'b0, out_limit};
      REG_MODE_BITS:       prdata = {29'd0, mode_bits};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_NEG;
      ST_NEG:    state_next = ST_ERR;
      ST_ERR:    state_next = ST_DBAND;
      ST_DBAND:  state_next = ST_PREP;
      ST_PREP:   state_next = ST_MUL_I;
      ST_MUL_I:  state_next = ST_MUL_DP;
      ST_MUL_DP: state_next = ST_MUL_DG;
      ST_MUL_DG: state_next = ST_SUM_D;
      ST_SUM_D:  state_next = ST_TOTAL;
      ST_TOTAL:  state_next = ST_CLIP;
      ST_CLIP:   state_next = ST_CERR;
      ST_CERR:   state_next = ST_MUL_AW;
      ST_MUL_AW: state_next = ST_FIN;
      ST_FIN:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_PREP: begin
        mul_a = gain_prop;
        mul_b = e;
      end
      ST_MUL_I: begin
        mul_a = gain_integ;
        mul_b = esum;
      end
      ST_MUL_DP: begin
        mul_a = deriv_pole;
        mul_b = deriv_accum;
      end
      ST_MUL_DG: begin
        mul_a = gd_zero ? 32'sd0 : gain_deriv;
        mul_b = diff;
      end
      // anti-windup product held while the result waits
      ST_MUL_AW, ST_FIN: begin
        mul_a = gain_antiwindup;
        mul_b = clip_err;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd <= command_value;
          act <= measured_value;
        end
      end
      ST_NEG: begin
        if (mode_bits[0]) cmd <= neg_sat(cmd);
        if (mode_bits[1]) begin
          act     <= neg_sat(act);
          neg_act <= (act == S32Min) ? S32Min + 32'sd1 : act;
        end else begin
          neg_act <= neg_sat(act);
        end
      end
      ST_ERR:  e <= sub_sat(cmd, act);
      ST_DBAND: begin
        if (mag <= {1'b0, dead_band}) begin
          e       <= '0;
          gd_zero <= !mode_bits[2];
        end else begin
          gd_zero <= 1'b0;
        end
      end
      ST_PREP: begin
        esum <= add_sat(e, last_error);
        diff <= mode_bits[2] ? sub_sat(neg_act, last_neg_measure) : sub_sat(e, last_error);
      end
      ST_MUL_I:  yp  <= mq;
      ST_MUL_DP: yi  <= add_sat(integ_accum, mq);
      ST_MUL_DG: ydp <= mq;
      ST_SUM_D:  yd  <= add_sat(ydp, mq);
      ST_TOTAL:  y   <= sat34(34'(yp) + 34'(yi) + 34'(yd));
      ST_CLIP: begin
        if (33'(y) >= $signed({2'b00, out_limit})) ys <= {1'b0, out_limit};
        else if (33'(y) <= -$signed({2'b00, out_limit})) ys <= -$signed({1'b0, out_limit});
        else ys <= y;
      end
      ST_CERR: clip_err <= sub_sat(ys, y);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error       <= '0;
      last_neg_measure <= '0;
      integ_accum      <= '0;
      deriv_accum      <= '0;
    end else if (state == ST_FIN && out_free) begin
      last_error       <= e;
      last_neg_measure <= neg_act;
      integ_accum      <= add_sat(yi, mq);
      deriv_accum      <= yd;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) drive_value <= ys;
  end

endmodule
`default_nettype wire
